// ----- design/slug_pkg.sv -----
package slug_pkg;

   localparam int MAX_SLUG_CHARS = 4095;
   localparam int QUEUE_DEPTH    = 4;
   localparam logic [11:0] MAX_CHARS_RESET = 12'd255;
   localparam logic [6:0] DASH_CHAR = 7'h2D;

   localparam logic [1:0] PH_START = 2'd0;
   localparam logic [1:0] PH_CHAR  = 2'd1;
   localparam logic [1:0] PH_END   = 2'd2;

   typedef struct packed {
      logic [1:0]      n;
      logic [2:0][6:0] chars;
   } slug_grp_type;

   typedef struct packed {
      logic            sep;
      logic            nz;
      logic            endf;
      logic [1:0]      n;
      logic [2:0][6:0] chars;
   } slug_tok_type;

   function automatic slug_grp_type map_code_point(input logic [15:0] cp);
      slug_grp_type g;
      logic [15:0]  lc;
      g.n = 2'd0;
      g.chars = '0;
      lc = cp;
      if (cp >= 16'h0041 && cp <= 16'h005A) begin
         lc = cp + 16'd32;
      end
      if ((lc >= 16'h0061 && lc <= 16'h007A) || (lc >= 16'h0030 && lc <= 16'h0039)) begin
         g.n = 2'd1;
         g.chars[0] = lc[6:0];
      end else begin
         unique case (cp) inside
            16'h00E4, 16'h00C4: begin
               g.n = 2'd2; g.chars[0] = 7'("a"); g.chars[1] = 7'("e");
            end
            16'h00F6, 16'h00D6: begin
               g.n = 2'd2; g.chars[0] = 7'("o"); g.chars[1] = 7'("e");
            end
            16'h00FC, 16'h00DC: begin
               g.n = 2'd2; g.chars[0] = 7'("u"); g.chars[1] = 7'("e");
            end
            16'h00DF: begin
               g.n = 2'd2; g.chars[0] = 7'("s"); g.chars[1] = 7'("s");
            end
            16'h00E0, 16'h00E1, 16'h00E2, 16'h00E3, 16'h00E5,
            16'h00C0, 16'h00C1, 16'h00C2, 16'h00C3, 16'h00C5: begin
               g.n = 2'd1; g.chars[0] = 7'("a");
            end
            16'h00E8, 16'h00E9, 16'h00EA, 16'h00EB,
            16'h00C8, 16'h00C9, 16'h00CA, 16'h00CB: begin
               g.n = 2'd1; g.chars[0] = 7'("e");
            end
            16'h00EC, 16'h00ED, 16'h00EE, 16'h00EF,
            16'h00CC, 16'h00CD, 16'h00CE, 16'h00CF: begin
               g.n = 2'd1; g.chars[0] = 7'("i");
            end
            16'h00F2, 16'h00F3, 16'h00F4, 16'h00F5, 16'h00F8,
            16'h00D2, 16'h00D3, 16'h00D4, 16'h00D5, 16'h00D8: begin
               g.n = 2'd1; g.chars[0] = 7'("o");
            end
            16'h00F9, 16'h00FA, 16'h00FB,
            16'h00D9, 16'h00DA, 16'h00DB: begin
               g.n = 2'd1; g.chars[0] = 7'("u");
            end
            16'h00E7, 16'h00C7: begin
               g.n = 2'd1; g.chars[0] = 7'("c");
            end
            16'h00F1, 16'h00D1: begin
               g.n = 2'd1; g.chars[0] = 7'("n");
            end
            16'h00FD, 16'h00FF, 16'h00DD: begin
               g.n = 2'd1; g.chars[0] = 7'("y");
            end
            16'h20AC: begin
               g.n = 2'd3; g.chars[0] = 7'("e"); g.chars[1] = 7'("u"); g.chars[2] = 7'("r");
            end
            default: begin
               g.n = 2'd0;
            end
         endcase
      end
      return g;
   endfunction

endpackage

// ----- design/slug_front.sv -----
module slug_front import slug_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_ready,
   input  logic [7:0]   req_title_byte,
   input  logic         req_title_last,
   output logic         push_valid,
   input  logic         push_ready,
   output slug_tok_type push_tok
);

   logic [1:0]   cont_ff, cont_in;
   logic [10:0]  part_ff, part_in;
   logic [16:0]  acc;
   logic         fresh;
   logic         have_cp;
   logic         bad;
   logic         nz;
   logic         endf;
   logic [15:0]  cp;
   slug_grp_type grp;
   logic         take;

   always_comb begin
      acc = {part_ff, req_title_byte[5:0]};
      cont_in = cont_ff;
      part_in = part_ff;
      fresh = 1'b0;
      have_cp = 1'b0;
      bad = 1'b0;
      cp = '0;
      nz = (req_title_byte != 8'h00);
      endf = !nz || req_title_last;
      if (nz) begin
         if (cont_ff != 2'd0) begin
            if (req_title_byte[7:6] == 2'b10) begin
               cont_in = cont_ff - 2'd1;
               if (cont_ff == 2'd1) begin
                  have_cp = 1'b1;
                  cp = acc[15:0];
                  part_in = '0;
               end else begin
                  part_in = acc[10:0];
               end
            end else begin
               bad = 1'b1;
               fresh = 1'b1;
               cont_in = 2'd0;
               part_in = '0;
            end
         end else begin
            fresh = 1'b1;
         end
         if (fresh) begin
            if (!req_title_byte[7]) begin
               have_cp = 1'b1;
               cp = {8'h00, req_title_byte};
            end else if (req_title_byte[7:5] == 3'b110) begin
               cont_in = 2'd1;
               part_in = {6'd0, req_title_byte[4:0]};
            end else if (req_title_byte[7:4] == 4'b1110) begin
               cont_in = 2'd2;
               part_in = {7'd0, req_title_byte[3:0]};
            end else begin
               bad = 1'b1;
            end
         end
      end
      if (endf) begin
         cont_in = 2'd0;
         part_in = '0;
      end
      grp = map_code_point(cp);
      push_tok.sep = bad || (have_cp && grp.n == 2'd0);
      push_tok.nz = nz;
      push_tok.endf = endf;
      push_tok.n = have_cp ? grp.n : 2'd0;
      push_tok.chars = grp.chars;
   end

   assign req_ready  = push_ready;
   assign push_valid = req_valid;
   assign take       = req_valid && push_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         cont_ff <= 2'd0;
         part_ff <= '0;
      end else if (take) begin
         cont_ff <= cont_in;
         part_ff <= part_in;
      end
   end

endmodule

// ----- design/slug_queue.sv -----
module slug_queue import slug_pkg::*; #(
   parameter int DEPTH = QUEUE_DEPTH
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         wr_valid,
   output logic         wr_ready,
   input  slug_tok_type wr_tok,
   output logic         rd_valid,
   input  logic         rd_ready,
   output slug_tok_type rd_tok
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   slug_tok_type         mem_ff [DEPTH];
   logic [PTR_W-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]     count_ff, count_in;
   logic                 do_wr;
   logic                 do_rd;

   assign wr_ready = (count_ff != CNT_W'(DEPTH));
   assign rd_valid = (count_ff != '0);
   assign rd_tok   = mem_ff[rd_ptr_ff];
   assign do_wr    = wr_valid && wr_ready;
   assign do_rd    = rd_valid && rd_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_wr) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_rd) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_wr && !do_rd) begin
         count_in = count_ff + 1'b1;
      end else if (do_rd && !do_wr) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (do_wr) begin
         mem_ff[wr_ptr_ff] <= wr_tok;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

// ----- design/slug_back.sv -----
module slug_back import slug_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         tok_valid,
   output logic         tok_ready,
   input  slug_tok_type tok,
   input  logic [11:0]  limit,
   output logic         rsp_valid,
   input  logic         rsp_ready,
   output logic [6:0]   rsp_out_char,
   output logic         rsp_char_valid,
   output logic         rsp_slug_done,
   output logic [11:0]  rsp_slug_length
);

   logic         work_valid_ff, work_valid_in;
   slug_tok_type work_ff, work_in;
   logic [1:0]   phase_ff, phase_in;
   logic [1:0]   idx_ff, idx_in;
   logic [11:0]  emitted_ff, emitted_in;
   logic         full_ff, full_in;
   logic         pend_ff, pend_in;
   logic         out_valid_ff, out_valid_in;
   logic [6:0]   out_char_ff;
   logic         out_cv_ff;
   logic         out_done_ff;
   logic [11:0]  out_len_ff;

   logic         adv;
   logic         step;
   logic         finish;
   logic         grp_done;
   logic         rec;
   logic [6:0]   rec_char;
   logic         rec_cv;
   logic         rec_done;
   logic [11:0]  rec_len;
   logic [12:0]  next_cnt;
   logic         room_dash;
   logic         reach;
   logic         blocked;
   logic         pend2;
   logic [6:0]   cur_char;

   assign adv       = !out_valid_ff || rsp_ready;
   assign step      = work_valid_ff && adv;
   assign next_cnt  = {1'b0, emitted_ff} + 13'd1;
   assign room_dash = next_cnt < {1'b0, limit};
   assign reach     = next_cnt >= {1'b0, limit};
   assign blocked   = full_ff || (emitted_ff >= limit);
   assign pend2     = pend_ff || (work_ff.sep && emitted_ff != 12'd0);

   always_comb begin
      case (idx_ff)
         2'd0:    cur_char = work_ff.chars[0];
         2'd1:    cur_char = work_ff.chars[1];
         default: cur_char = work_ff.chars[2];
      endcase
   end

   always_comb begin
      phase_in   = phase_ff;
      idx_in     = idx_ff;
      emitted_in = emitted_ff;
      full_in    = full_ff;
      pend_in    = pend_ff;
      finish     = 1'b0;
      grp_done   = 1'b0;
      rec        = 1'b0;
      rec_char   = 7'd0;
      rec_cv     = 1'b0;
      rec_done   = 1'b0;
      rec_len    = emitted_ff;
      if (step) begin
         unique case (phase_ff)
            PH_START: begin
               if (!work_ff.nz) begin
                  grp_done = 1'b1;
               end else if (blocked) begin
                  full_in = 1'b1;
                  grp_done = 1'b1;
               end else if (work_ff.n == 2'd0) begin
                  pend_in = pend2;
                  grp_done = 1'b1;
               end else if (pend2) begin
                  pend_in = 1'b0;
                  if (room_dash) begin
                     rec = 1'b1;
                     rec_char = DASH_CHAR;
                     rec_cv = 1'b1;
                     rec_len = next_cnt[11:0];
                     emitted_in = next_cnt[11:0];
                     phase_in = PH_CHAR;
                     idx_in = 2'd0;
                  end else begin
                     full_in = 1'b1;
                     grp_done = 1'b1;
                  end
               end else begin
                  rec = 1'b1;
                  rec_char = work_ff.chars[0];
                  rec_cv = 1'b1;
                  rec_len = next_cnt[11:0];
                  emitted_in = next_cnt[11:0];
                  if (reach) begin
                     full_in = 1'b1;
                  end
                  if (work_ff.n == 2'd1 || reach) begin
                     grp_done = 1'b1;
                  end else begin
                     phase_in = PH_CHAR;
                     idx_in = 2'd1;
                  end
               end
            end
            PH_CHAR: begin
               rec = 1'b1;
               rec_char = cur_char;
               rec_cv = 1'b1;
               rec_len = next_cnt[11:0];
               emitted_in = next_cnt[11:0];
               if (reach) begin
                  full_in = 1'b1;
               end
               if (idx_ff == work_ff.n - 2'd1 || reach) begin
                  grp_done = 1'b1;
               end else begin
                  idx_in = idx_ff + 2'd1;
               end
            end
            PH_END: begin
               rec = 1'b1;
               rec_done = 1'b1;
               rec_len = emitted_ff;
               emitted_in = '0;
               full_in = 1'b0;
               pend_in = 1'b0;
               finish = 1'b1;
            end
            default: begin
               finish = 1'b1;
            end
         endcase
         if (grp_done) begin
            if (!work_ff.endf) begin
               finish = 1'b1;
            end else if (!rec) begin
               rec = 1'b1;
               rec_done = 1'b1;
               rec_len = emitted_ff;
               emitted_in = '0;
               full_in = 1'b0;
               pend_in = 1'b0;
               finish = 1'b1;
            end else begin
               phase_in = PH_END;
            end
         end
      end
      if (tok_valid && (!work_valid_ff || finish)) begin
         phase_in = PH_START;
      end
   end

   assign tok_ready = !work_valid_ff || finish;

   always_comb begin
      work_valid_in = work_valid_ff;
      work_in = work_ff;
      if (finish) begin
         work_valid_in = 1'b0;
      end
      if (tok_valid && tok_ready) begin
         work_valid_in = 1'b1;
         work_in = tok;
      end
      out_valid_in = adv ? rec : out_valid_ff;
   end

   always_ff @(posedge clock) begin
      work_ff <= work_in;
      idx_ff <= idx_in;
      if (adv && rec) begin
         out_char_ff <= rec_char;
         out_cv_ff   <= rec_cv;
         out_done_ff <= rec_done;
         out_len_ff  <= rec_len;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         work_valid_ff <= 1'b0;
         phase_ff      <= PH_START;
         emitted_ff    <= '0;
         full_ff       <= 1'b0;
         pend_ff       <= 1'b0;
         out_valid_ff  <= 1'b0;
      end else begin
         work_valid_ff <= work_valid_in;
         phase_ff      <= phase_in;
         emitted_ff    <= emitted_in;
         full_ff       <= full_in;
         pend_ff       <= pend_in;
         out_valid_ff  <= out_valid_in;
      end
   end

   assign rsp_valid       = out_valid_ff;
   assign rsp_out_char    = out_char_ff;
   assign rsp_char_valid  = out_cv_ff;
   assign rsp_slug_done   = out_done_ff;
   assign rsp_slug_length = out_len_ff;

endmodule

// ----- design/utf8_text_slug_generator.sv -----
// A request's token passes the token queue, work and output registers before its first
// record appears. Throughput while rsp_ready is high: one request per cycle while each
// yields at most one record; a request yields up to five records (dash, three letters,
// end record), one per cycle, and the queue absorbs the input meanwhile until it fills.
// Reset: synchronous, active high; clears decoder, queue, counters and output,
// and sets the character limit to 255.
module utf8_text_slug_generator import slug_pkg::*; #(
   parameter int DEPTH = QUEUE_DEPTH
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_title_byte,
   input  logic        req_title_last,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [6:0]  rsp_out_char,
   output logic        rsp_char_valid,
   output logic        rsp_slug_done,
   output logic [11:0] rsp_slug_length,
   input  logic        csr_wr_en,
   input  logic [11:0] csr_wr_data
);

   logic [11:0]  max_chars_ff;
   logic [11:0]  limit;
   logic         push_valid;
   logic         push_ready;
   slug_tok_type push_tok;
   logic         pop_valid;
   logic         pop_ready;
   slug_tok_type pop_tok;

   always_ff @(posedge clock) begin
      if (reset) begin
         max_chars_ff <= MAX_CHARS_RESET;
      end else if (csr_wr_en) begin
         max_chars_ff <= csr_wr_data;
      end
   end

   assign limit = ({4'd0, max_chars_ff} > 16'(MAX_SLUG_CHARS)) ?
                  12'(MAX_SLUG_CHARS) : max_chars_ff;

   slug_front u_front (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_title_byte (req_title_byte),
      .req_title_last (req_title_last),
      .push_valid     (push_valid),
      .push_ready     (push_ready),
      .push_tok       (push_tok)
   );

   slug_queue #(.DEPTH(DEPTH)) u_queue (
      .clock    (clock),
      .reset    (reset),
      .wr_valid (push_valid),
      .wr_ready (push_ready),
      .wr_tok   (push_tok),
      .rd_valid (pop_valid),
      .rd_ready (pop_ready),
      .rd_tok   (pop_tok)
   );

   slug_back u_back (
      .clock           (clock),
      .reset           (reset),
      .tok_valid       (pop_valid),
      .tok_ready       (pop_ready),
      .tok             (pop_tok),
      .limit           (limit),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_out_char    (rsp_out_char),
      .rsp_char_valid  (rsp_char_valid),
      .rsp_slug_done   (rsp_slug_done),
      .rsp_slug_length (rsp_slug_length)
   );

endmodule

// ----- design/slug_checker.sv -----
module slug_assertions import slug_pkg::*; (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [6:0]  rsp_out_char,
   input logic        rsp_char_valid,
   input logic        rsp_slug_done,
   input logic [11:0] rsp_slug_length
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_out_char) &&
      $stable(rsp_char_valid) && $stable(rsp_slug_done) && $stable(rsp_slug_length))
      else $error("response changed while stalled");

   a_end_record: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_slug_done |-> !rsp_char_valid && rsp_out_char == 7'd0)
      else $error("end record carries a character");

   a_char_record: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_char_valid |-> !rsp_slug_done && rsp_slug_length != 12'd0)
      else $error("character record with zero length or done flag");

   a_no_lead_dash: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_char_valid && rsp_slug_length == 12'd1 |-> rsp_out_char != DASH_CHAR)
      else $error("slug starts with a dash");

endmodule

bind utf8_text_slug_generator slug_assertions u_slug_assertions (
   .clock           (clock),
   .reset           (reset),
   .rsp_valid       (rsp_valid),
   .rsp_ready       (rsp_ready),
   .rsp_out_char    (rsp_out_char),
   .rsp_char_valid  (rsp_char_valid),
   .rsp_slug_done   (rsp_slug_done),
   .rsp_slug_length (rsp_slug_length)
);
